>>> design/edp_pkg.sv
package edp_pkg;

  localparam int REQ_W      = 2;
  localparam int PCT_W      = 8;
  localparam int SBASE_W    = 16;
  localparam int FBASE_W    = 16;
  localparam int STEP_W     = 8;
  localparam int CAP_W      = 20;
  localparam int FCNT_W     = 8;
  localparam int EXP_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POLL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_CAP  = 2'd3;

  localparam logic [SBASE_W-1:0] SBASE_RST = 16'd25;
  localparam logic [FBASE_W-1:0] FBASE_RST = 16'd50;
  localparam logic [STEP_W-1:0]  STEP_RST  = 8'd5;
  localparam logic [CAP_W-1:0]   CAP_RST   = 20'd15000;

  localparam int SPROD_W = SBASE_W + PCT_W;
  localparam int NSQ_W   = 2 * FCNT_W;
  localparam int FSTEP_W = NSQ_W + STEP_W;
  localparam int FRAW_W  = FSTEP_W + 1;
  localparam int FPROD_W = CAP_W + PCT_W;
  localparam int GAP_W   = 22;

  // x / 100 == (x * RECIP_100) >> RECIP_SH, exact for x below 2^30
  localparam int                 DIV_W     = FPROD_W;
  localparam int                 RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] RECIP_100 = 29'd343597384;
  localparam int                 RECIP_SH  = 35;

endpackage

>>> design/edp_if.sv
interface edp_req_if #(
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic [edp_pkg::REQ_W-1:0]  req_type;
  logic [ID_BITS-1:0]         task_id;
  logic [TIME_BITS-1:0]       task_deadline;
  logic [TIME_BITS-1:0]       now_ms;
  logic [TIME_BITS-1:0]       now_deadline_clock;
  logic [edp_pkg::PCT_W-1:0]  rand_pct;
  logic                       success;

  modport source (output valid, req_type, task_id, task_deadline, now_ms,
                  now_deadline_clock, rand_pct, success, input ready);
  modport sink   (input valid, req_type, task_id, task_deadline, now_ms,
                  now_deadline_clock, rand_pct, success, output ready);
endinterface

interface edp_rsp_if #(
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic                       dispatched;
  logic [ID_BITS-1:0]         dispatched_id;
  logic [TIME_BITS-1:0]       dispatched_deadline;
  logic [edp_pkg::EXP_W-1:0]  expired_count;
  logic                       accepted;

  modport source (output valid, dispatched, dispatched_id, dispatched_deadline,
                  expired_count, accepted, input ready);
  modport sink   (input valid, dispatched, dispatched_id, dispatched_deadline,
                  expired_count, accepted, output ready);
endinterface

>>> design/edp_div100.sv
module edp_div100 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [edp_pkg::DIV_W-1:0] dividend_i,
  output logic                      busy_o,
  output logic [edp_pkg::DIV_W-1:0] quotient_o
);
  import edp_pkg::*;

  localparam int PROD_W = DIV_W + RECIP_W;

  logic              busy_q, busy_d;
  logic [DIV_W-1:0]  din_q, din_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(din_q) * PROD_W'(RECIP_100);

  always_comb begin
    busy_d = start_i;
    din_d  = start_i ? dividend_i : din_q;
    quo_d  = busy_q ? DIV_W'(prod >> RECIP_SH) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    din_q <= din_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> design/edf_task_dispatch_with_backoff.sv
// Earliest-deadline-first task table with paced dispatch and failure backoff.
// Channels: req (sink) carries enqueue, poll and report transactions; rsp
// (source) returns exactly one result transaction per request, in order.
// cfg_we_i/cfg_idx_i/cfg_data_i write the four pacing registers; write only
// while the block is idle.
// Enqueue, report and unused codes go from idle straight to the result stage.
// A poll runs an expiry pass over the table, four multiply and clamp stages,
// two divide-by-100 steps in the shared reciprocal-multiply divider, and,
// when dispatch is allowed, a minimum-search pass and a removal pass.
// Each pass moves one entry per cycle through the single read port of
// the table memory.
// One request is processed at a time; req.ready is high only while idle.
// The finished result sits in an output register, so the next request is
// taken while it waits; a further result waits until rsp is drained.
// Reset clears the table count, pacing history and registers to defaults.
module edf_task_dispatch_with_backoff #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  edp_req_if.sink                        req,
  edp_rsp_if.source                      rsp,
  input  logic                           cfg_we_i,
  input  logic [edp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [edp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import edp_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SUM_W = ((TIME_BITS > GAP_W) ? TIME_BITS : GAP_W) + 1;
  localparam bit CAN_OVF = (SUM_W > 64);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_CMP   = 12'b000000000010,
    ST_MUL1  = 12'b000000000100,
    ST_MUL2  = 12'b000000001000,
    ST_MUL3  = 12'b000000010000,
    ST_MUL4  = 12'b000000100000,
    ST_DIVS  = 12'b000001000000,
    ST_DIVF  = 12'b000010000000,
    ST_GATE  = 12'b000100000000,
    ST_SCAN  = 12'b001000000000,
    ST_SHIFT = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] dl;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t mem_rdata_q;
  entry_t mem_wdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;

  state_e state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_BITS-1:0] lst_q, lst_d, lft_q, lft_d;
  logic [FCNT_W-1:0]    fcnt_q, fcnt_d;
  logic [PCT_W-1:0]     ipct_q, ipct_d;
  logic [SBASE_W-1:0]   sbase_q, sbase_d;
  logic [FBASE_W-1:0]   fbase_q, fbase_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [CAP_W-1:0]     cap_q, cap_d;
  logic [TIME_BITS-1:0] now_q, now_d, dclk_q, dclk_d;

  logic [CNT_W-1:0]     rp_q, rp_d, wp_q, wp_d, aidx_q, aidx_d, best_q, best_d;
  logic                 rv_q, rv_d;
  logic [TIME_BITS-1:0] best_dl_q, best_dl_d;
  logic [ID_BITS-1:0]   best_id_q, best_id_d;
  logic [EXP_W-1:0]     exp_q, exp_d;

  logic [SPROD_W-1:0]   sprod_q, sprod_d;
  logic [NSQ_W-1:0]     nsq_q, nsq_d;
  logic [FSTEP_W-1:0]   fstep_q, fstep_d;
  logic [FRAW_W-1:0]    fraw;
  logic [CAP_W-1:0]     fcl_q, fcl_d;
  logic [FPROD_W-1:0]   fprod_q, fprod_d;
  logic [GAP_W-1:0]     sgap_q, sgap_d, fgap_q, fgap_d;

  logic                 acc_q, acc_d, disp_q, disp_d;
  logic [ID_BITS-1:0]   did_q, did_d;
  logic [TIME_BITS-1:0] ddl_q, ddl_d;

  logic                 ov_q, ov_d, o_disp_q, o_disp_d, o_acc_q, o_acc_d;
  logic [ID_BITS-1:0]   o_id_q, o_id_d;
  logic [TIME_BITS-1:0] o_dl_q, o_dl_d;
  logic [EXP_W-1:0]     o_exp_q, o_exp_d;

  logic                 div_start, div_busy;
  logic [DIV_W-1:0]     div_din, div_quo;

  logic [SUM_W-1:0]     ssum, fsum;
  logic                 sblk, fblk, pace_open, in_acc;

  edp_div100 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_din),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  assign req.ready = (state_q == ST_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign mem_raddr = rp_q[IDX_W-1:0];

  assign ssum = SUM_W'(lst_q) + SUM_W'(sgap_q);
  assign fsum = SUM_W'(lft_q) + SUM_W'(fgap_q);
  assign sblk = (CAN_OVF && ssum[SUM_W-1]) ? (now_q != '1) : (ssum > SUM_W'(now_q));
  assign fblk = (CAN_OVF && fsum[SUM_W-1]) ? (now_q != '1) : (fsum > SUM_W'(now_q));
  assign pace_open = !sblk && !fblk;
  assign fraw = FRAW_W'(fbase_q) + FRAW_W'(fstep_q);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;   lst_d = lst_q;   lft_d = lft_q;
    fcnt_d = fcnt_q; ipct_d = ipct_q;
    sbase_d = sbase_q; fbase_d = fbase_q; step_d = step_q; cap_d = cap_q;
    now_d = now_q;   dclk_d = dclk_q;
    rp_d = rp_q; wp_d = wp_q; aidx_d = aidx_q; best_d = best_q; rv_d = 1'b0;
    best_dl_d = best_dl_q; best_id_d = best_id_q; exp_d = exp_q;
    sprod_d = sprod_q; nsq_d = nsq_q; fstep_d = fstep_q; fcl_d = fcl_q;
    fprod_d = fprod_q; sgap_d = sgap_q; fgap_d = fgap_q;
    acc_d = acc_q; disp_d = disp_q; did_d = did_q; ddl_d = ddl_q;
    ov_d = ov_q && !rsp.ready;
    o_disp_d = o_disp_q; o_acc_d = o_acc_q; o_id_d = o_id_q;
    o_dl_d = o_dl_q; o_exp_d = o_exp_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = mem_rdata_q;
    div_start = 1'b0; div_din = DIV_W'(sprod_q);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUCCESS_BASE: sbase_d = cfg_data_i[SBASE_W-1:0];
        CFG_FAILURE_BASE: fbase_d = cfg_data_i[FBASE_W-1:0];
        CFG_FAILURE_STEP: step_d  = cfg_data_i[STEP_W-1:0];
        CFG_FAILURE_CAP:  cap_d   = cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          acc_d = 1'b0; disp_d = 1'b0; did_d = '0; ddl_d = '0; exp_d = '0;
          state_d = ST_DONE;
          case (req.req_type)
            REQ_ENQ: begin
              if (cnt_q < CNT_W'(TABLE_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IDX_W-1:0];
                mem_wdata = '{id: req.task_id, dl: req.task_deadline};
                cnt_d     = cnt_q + 1'b1;
                acc_d     = 1'b1;
              end
            end
            REQ_POLL: begin
              now_d  = req.now_ms;
              dclk_d = req.now_deadline_clock;
              if (ipct_q == '0) begin
                ipct_d = req.rand_pct;
              end
              rp_d = '0;
              wp_d = '0;
              state_d = ST_CMP;
            end
            REQ_REPORT: begin
              ipct_d = req.rand_pct;
              if (req.success) begin
                lst_d  = req.now_ms;
                lft_d  = '0;
                fcnt_d = '0;
              end else begin
                lst_d = '0;
                lft_d = req.now_ms;
                if (fcnt_q != '1) begin
                  fcnt_d = fcnt_q + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (rp_q < cnt_q) begin
          rp_d = rp_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          if (mem_rdata_q.dl > dclk_q) begin
            mem_we    = 1'b1;
            mem_waddr = wp_q[IDX_W-1:0];
            wp_d      = wp_q + 1'b1;
          end else begin
            exp_d = exp_q + 1'b1;
          end
        end
        if (rp_q == cnt_q && !rv_q) begin
          cnt_d   = wp_q;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        sprod_d = SPROD_W'(sbase_q) * SPROD_W'(ipct_q);
        nsq_d   = NSQ_W'(fcnt_q) * NSQ_W'(fcnt_q);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        fstep_d = FSTEP_W'(nsq_q) * FSTEP_W'(step_q);
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        fcl_d   = (fraw > FRAW_W'(cap_q)) ? cap_q : fraw[CAP_W-1:0];
        state_d = ST_MUL4;
      end
      ST_MUL4: begin
        fprod_d   = FPROD_W'(fcl_q) * FPROD_W'(ipct_q);
        div_start = 1'b1;
        div_din   = DIV_W'(sprod_q);
        state_d   = ST_DIVS;
      end
      ST_DIVS: begin
        if (!div_busy) begin
          sgap_d = (div_quo > DIV_W'(sbase_q)) ? GAP_W'(div_quo) : GAP_W'(sbase_q);
          div_start = 1'b1;
          div_din   = fprod_q;
          state_d   = ST_DIVF;
        end
      end
      ST_DIVF: begin
        if (!div_busy) begin
          fgap_d  = (div_quo > DIV_W'(fbase_q)) ? GAP_W'(div_quo) : GAP_W'(fbase_q);
          state_d = ST_GATE;
        end
      end
      ST_GATE: begin
        if (pace_open && cnt_q != '0) begin
          rp_d    = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (rp_q < cnt_q) begin
          rp_d   = rp_q + 1'b1;
          aidx_d = rp_q;
          rv_d   = 1'b1;
        end
        if (rv_q && (aidx_q == '0 || mem_rdata_q.dl < best_dl_q)) begin
          best_d    = aidx_q;
          best_dl_d = mem_rdata_q.dl;
          best_id_d = mem_rdata_q.id;
        end
        if (rp_q == cnt_q && !rv_q) begin
          disp_d  = 1'b1;
          did_d   = best_id_q;
          ddl_d   = best_dl_q;
          rp_d    = best_q + 1'b1;
          wp_d    = best_q;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (rp_q < cnt_q) begin
          rp_d = rp_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = wp_q[IDX_W-1:0];
          wp_d      = wp_q + 1'b1;
        end
        if (rp_q == cnt_q && !rv_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || rsp.ready) begin
          ov_d     = 1'b1;
          o_disp_d = disp_q;
          o_id_d   = did_q;
          o_dl_d   = ddl_q;
          o_exp_d  = exp_q;
          o_acc_d  = acc_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      lst_q   <= '0;
      lft_q   <= '0;
      fcnt_q  <= '0;
      ipct_q  <= '0;
      sbase_q <= SBASE_RST;
      fbase_q <= FBASE_RST;
      step_q  <= STEP_RST;
      cap_q   <= CAP_RST;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lst_q   <= lst_d;
      lft_q   <= lft_d;
      fcnt_q  <= fcnt_d;
      ipct_q  <= ipct_d;
      sbase_q <= sbase_d;
      fbase_q <= fbase_d;
      step_q  <= step_d;
      cap_q   <= cap_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    dclk_q    <= dclk_d;
    rp_q      <= rp_d;
    wp_q      <= wp_d;
    aidx_q    <= aidx_d;
    best_q    <= best_d;
    best_dl_q <= best_dl_d;
    best_id_q <= best_id_d;
    exp_q     <= exp_d;
    sprod_q   <= sprod_d;
    nsq_q     <= nsq_d;
    fstep_q   <= fstep_d;
    fcl_q     <= fcl_d;
    fprod_q   <= fprod_d;
    sgap_q    <= sgap_d;
    fgap_q    <= fgap_d;
    acc_q     <= acc_d;
    disp_q    <= disp_d;
    did_q     <= did_d;
    ddl_q     <= ddl_d;
    o_disp_q  <= o_disp_d;
    o_id_q    <= o_id_d;
    o_dl_q    <= o_dl_d;
    o_exp_q   <= o_exp_d;
    o_acc_q   <= o_acc_d;
  end

  assign rsp.valid               = ov_q;
  assign rsp.dispatched          = o_disp_q;
  assign rsp.dispatched_id       = o_id_q;
  assign rsp.dispatched_deadline = o_dl_q;
  assign rsp.expired_count       = o_exp_q;
  assign rsp.accepted            = o_acc_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("task count above table depth");

  a_full_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req.req_type == REQ_ENQ && cnt_q == CNT_W'(TABLE_DEPTH))
      |=> $stable(cnt_q))
    else $error("enqueue on full table changed count");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");
`endif

endmodule
